// ===== hdl/rgb_led_button_gesture_dimmer_core_macros.svh =====
// Assertion macros for the gesture dimmer core.
// Used by rgb_led_button_gesture_dimmer_core.sv; no other dependencies.
`ifndef RGB_LED_BUTTON_GESTURE_DIMMER_CORE_MACROS_SVH
`define RGB_LED_BUTTON_GESTURE_DIMMER_CORE_MACROS_SVH

// same-cycle implication
`define RGBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rgbd_pkg.sv =====
// Shared types and constants for the gesture dimmer core.
// No dependencies; used by the interfaces, rgbd_button and the top level.
package rgbd_pkg;

  localparam int unsigned DUTY_BITS_DEF = 8;
  localparam int unsigned PERIOD_BITS   = 16;
  localparam int unsigned LIMIT_BITS    = 8;
  localparam int unsigned HOLD_BITS     = 8;
  localparam int unsigned WIDTH_BITS    = 15;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = 15'd32767;

  // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam int unsigned RECIP_BITS  = 29;
  localparam logic [RECIP_BITS-1:0] RECIP_1000 = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RST = 16'd11362;
  localparam logic [LIMIT_BITS-1:0]  FLOOR_RST  = 8'd10;
  localparam logic [LIMIT_BITS-1:0]  CEIL_RST   = 8'd254;
  localparam logic [HOLD_BITS-1:0]   HOLD_RST   = 8'd25;
  localparam logic [15:0]            RED_RST    = 16'd10;
  localparam logic [15:0]            GREEN_RST  = 16'd254;
  localparam logic [15:0]            BLUE_RST   = 16'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEIL   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD   = 2'd3;

  // adjust target codes
  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_RED   = 2'd1;
  localparam logic [1:0] TGT_GREEN = 2'd2;
  localparam logic [1:0] TGT_BLUE  = 2'd3;

  typedef struct packed {
    logic                 idle;
    logic                 fresh;
    logic [HOLD_BITS-1:0] count;
    logic                 long_hold;
  } btn_t;

  // saturate a reset value to a duty width of the given bit count
  function automatic logic [15:0] cap_duty(input logic [15:0] v, input int unsigned bits);
    logic [16:0] dmax;
    dmax = (17'd1 << bits) - 17'd1;
    cap_duty = ({1'b0, v} > dmax) ? dmax[15:0] : v;
  endfunction

endpackage

// ===== hdl/rgbd_if.sv =====
// Valid/ready channel interfaces of the gesture dimmer core.
// Depends on rgbd_pkg for field widths.
interface rgbd_in_if;
  logic valid;
  logic ready;
  logic button_a_down;
  logic button_b_down;
  modport source (output valid, output button_a_down, output button_b_down, input ready);
  modport sink   (input valid, input button_a_down, input button_b_down, output ready);
endinterface

interface rgbd_out_if;
  logic                            valid;
  logic                            ready;
  logic [rgbd_pkg::WIDTH_BITS-1:0] red_width;
  logic [rgbd_pkg::WIDTH_BITS-1:0] green_width;
  logic [rgbd_pkg::WIDTH_BITS-1:0] blue_width;
  logic [1:0]                      selected_channel;
  modport source (output valid, output red_width, output green_width, output blue_width,
                  output selected_channel, input ready);
  modport sink   (input valid, input red_width, input green_width, input blue_width,
                  input selected_channel, output ready);
endinterface

interface rgbd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rgbd_pkg::CFG_IDX_BITS-1:0]  index;
  logic [rgbd_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rgb_led_button_gesture_dimmer_core.sv =====
// Top level of the two-button RGB gesture dimmer with PWM width scaling.
// Depends on rgbd_pkg, rgbd_if.sv, rgbd_button and the assertion macro header.
//
//  channel | dir | payload                                          | accepted when
//  in_i    | in  | button_a_down, button_b_down                     | valid && ready
//  out_o   | out | red/green/blue_width, selected_channel           | valid && ready
//  cfg_i   | in  | index (0 period, 1 floor, 2 ceiling, 3 hold), data | valid (ready is 1)
//
// One tick per cycle unless the output stalls; stages: gesture/duty update
// into the state registers, duty*period multiply, then reciprocal multiply
// for /1000 into the output register. Each stage advances when the next one
// is empty or moving, so a stalled output still lets bubbles fill. Reset
// clears control state and loads the register defaults; no clearing pass.
`include "rgb_led_button_gesture_dimmer_core_macros.svh"

module rgb_led_button_gesture_dimmer_core #(
  parameter int unsigned DUTY_BITS = rgbd_pkg::DUTY_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rgbd_in_if.sink    in_i,
  rgbd_out_if.source out_o,
  rgbd_cfg_if.sink   cfg_i
);

  localparam int unsigned EW = ((DUTY_BITS > rgbd_pkg::LIMIT_BITS) ? DUTY_BITS
                                                                   : rgbd_pkg::LIMIT_BITS) + 1;
  localparam int unsigned PW = DUTY_BITS + rgbd_pkg::PERIOD_BITS;
  localparam int unsigned QW = PW + rgbd_pkg::RECIP_BITS;
  localparam logic [EW-1:0] DMAX = EW'((32'd1 << DUTY_BITS) - 32'd1);
  localparam logic [DUTY_BITS-1:0] RED_INIT =
    DUTY_BITS'(rgbd_pkg::cap_duty(rgbd_pkg::RED_RST, DUTY_BITS));
  localparam logic [DUTY_BITS-1:0] GREEN_INIT =
    DUTY_BITS'(rgbd_pkg::cap_duty(rgbd_pkg::GREEN_RST, DUTY_BITS));
  localparam logic [DUTY_BITS-1:0] BLUE_INIT =
    DUTY_BITS'(rgbd_pkg::cap_duty(rgbd_pkg::BLUE_RST, DUTY_BITS));

  // ---------------- configuration ----------------
  logic [rgbd_pkg::PERIOD_BITS-1:0] period_q;
  logic [rgbd_pkg::LIMIT_BITS-1:0]  floor_q, ceil_q;
  logic [rgbd_pkg::HOLD_BITS-1:0]   hold_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= rgbd_pkg::PERIOD_RST;
      floor_q  <= rgbd_pkg::FLOOR_RST;
      ceil_q   <= rgbd_pkg::CEIL_RST;
      hold_q   <= rgbd_pkg::HOLD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rgbd_pkg::REG_PERIOD: period_q <= cfg_i.data;
        rgbd_pkg::REG_FLOOR:  floor_q  <= cfg_i.data[rgbd_pkg::LIMIT_BITS-1:0];
        rgbd_pkg::REG_CEIL:   ceil_q   <= cfg_i.data[rgbd_pkg::LIMIT_BITS-1:0];
        rgbd_pkg::REG_HOLD:   hold_q   <= cfg_i.data[rgbd_pkg::HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic v1_q, v2_q, out_vld_q;
  logic en1, en2, out_en, in_acc;

  assign out_en     = !out_vld_q || out_o.ready;
  assign en2        = !v2_q || out_en;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;
  assign in_acc     = in_i.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1)    v1_q      <= in_i.valid;
      if (en2)    v2_q      <= v1_q;
      if (out_en) out_vld_q <= v2_q;
    end
  end

  // ---------------- gesture classification ----------------
  rgbd_pkg::btn_t a_st, a_nx, b_st, b_nx;

  rgbd_button u_btn_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_acc),
    .down_i  (in_i.button_a_down),
    .limit_i (hold_q),
    .state_o (a_st),
    .next_o  (a_nx)
  );

  rgbd_button u_btn_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_acc),
    .down_i  (in_i.button_b_down),
    .limit_i (hold_q),
    .state_o (b_st),
    .next_o  (b_nx)
  );

  // ---------------- selection and duty update ----------------
  // The state registers double as stage 1: they only change on the next
  // transaction, which needs stage 1 to be moving.
  logic [1:0]           spc_q, spc_d, spc_base, spc_inc;
  logic [1:0]           tgt_q, tgt_d;
  logic [DUTY_BITS-1:0] duty_q [3];
  logic [DUTY_BITS-1:0] duty_d [3];
  logic [DUTY_BITS-1:0] cur_duty, adj_duty;

  function automatic logic [DUTY_BITS-1:0] raise_duty(input logic [DUTY_BITS-1:0] d,
                                                       input logic [EW-1:0] ceil);
    logic [EW-1:0] n;
    n = EW'(d) + EW'(1);
    if (n > DMAX) n = DMAX;
    if (n > ceil) n = ceil;
    if (n > DMAX) n = DMAX;
    raise_duty = n[DUTY_BITS-1:0];
  endfunction

  function automatic logic [DUTY_BITS-1:0] lower_duty(input logic [DUTY_BITS-1:0] d,
                                                       input logic [EW-1:0] flr);
    logic [EW-1:0] n;
    n = (d == '0) ? '0 : EW'(d) - EW'(1);
    if (n < flr) n = flr;
    if (n > DMAX) n = DMAX;
    lower_duty = n[DUTY_BITS-1:0];
  endfunction

  always_comb begin
    spc_base = in_i.button_b_down ? spc_q : 2'd0;
    spc_inc  = spc_base + 2'd1;
    spc_d    = spc_base;
    tgt_d    = tgt_q;
    if (b_nx.long_hold && a_nx.fresh) begin
      if (spc_inc == 2'd1) begin
        spc_d = 2'd1;
        tgt_d = rgbd_pkg::TGT_RED;
      end else if (spc_inc == 2'd2) begin
        spc_d = 2'd2;
        tgt_d = rgbd_pkg::TGT_GREEN;
      end else begin
        spc_d = 2'd0;
      end
    end
    if (b_nx.long_hold && a_nx.long_hold) tgt_d = rgbd_pkg::TGT_BLUE;

    case (tgt_d)
      rgbd_pkg::TGT_RED:   cur_duty = duty_q[0];
      rgbd_pkg::TGT_GREEN: cur_duty = duty_q[1];
      rgbd_pkg::TGT_BLUE:  cur_duty = duty_q[2];
      default:             cur_duty = '0;
    endcase

    // raise first, then lower, when both buttons are down
    adj_duty = cur_duty;
    if (in_i.button_b_down) adj_duty = raise_duty(adj_duty, EW'(ceil_q));
    if (in_i.button_a_down) adj_duty = lower_duty(adj_duty, EW'(floor_q));

    duty_d[0] = (tgt_d == rgbd_pkg::TGT_RED)   ? adj_duty : duty_q[0];
    duty_d[1] = (tgt_d == rgbd_pkg::TGT_GREEN) ? adj_duty : duty_q[1];
    duty_d[2] = (tgt_d == rgbd_pkg::TGT_BLUE)  ? adj_duty : duty_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q     <= 2'd0;
      tgt_q     <= rgbd_pkg::TGT_NONE;
      duty_q[0] <= RED_INIT;
      duty_q[1] <= GREEN_INIT;
      duty_q[2] <= BLUE_INIT;
    end else if (in_acc) begin
      spc_q  <= spc_d;
      tgt_q  <= tgt_d;
      duty_q <= duty_d;
    end
  end

  // ---------------- width scaling: duty * period / 1000 ----------------
  logic [PW-1:0]                   prod_q [3];
  logic [rgbd_pkg::WIDTH_BITS-1:0] width_q [3];
  logic [1:0]                      sel2_q, sel_out_q;

  for (genvar ch = 0; ch < 3; ch++) begin : g_scale
    logic [QW-1:0] scaled;
    logic [31:0]   quot;

    assign scaled = QW'(prod_q[ch]) * QW'(rgbd_pkg::RECIP_1000);
    assign quot   = 32'(scaled >> rgbd_pkg::RECIP_SHIFT);

    always_ff @(posedge clk_i) begin
      if (en2) prod_q[ch] <= PW'(duty_q[ch]) * PW'(period_q);
      if (out_en) begin
        width_q[ch] <= (quot > 32'(rgbd_pkg::WIDTH_MAX)) ? rgbd_pkg::WIDTH_MAX
                                                         : quot[rgbd_pkg::WIDTH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2)    sel2_q    <= tgt_q;
    if (out_en) sel_out_q <= sel2_q;
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.red_width        = width_q[0];
  assign out_o.green_width      = width_q[1];
  assign out_o.blue_width       = width_q[2];
  assign out_o.selected_channel = sel_out_q;

  // ---------------- assertions ----------------
  `RGBD_ASSERT_NXT(a_spc_clear, clk_i, rst_ni, in_acc && !in_i.button_b_down, spc_q == 2'd0, "press count kept after B release")
  `RGBD_ASSERT_IMP(a_long_not_idle, clk_i, rst_ni, a_st.long_hold || b_st.long_hold, !(a_st.long_hold && a_st.idle) && !(b_st.long_hold && b_st.idle), "long hold on an idle button")
  `RGBD_ASSERT_IMP(a_out_from_pipe, clk_i, rst_ni, $rose(out_vld_q), $past(v2_q), "result without a stage 2 entry")
  `RGBD_ASSERT_IMP(a_duty_on_accept, clk_i, rst_ni, !$stable(duty_q[0]) || !$stable(duty_q[1]) || !$stable(duty_q[2]), $past(in_acc), "duty changed without a transaction")

endmodule

// ===== hdl/rgbd_button.sv =====
// Press classifier for one button: fresh press, hold count, long-hold flag.
// Depends on rgbd_pkg (btn_t, widths).
module rgbd_button (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           down_i,
  input  logic [rgbd_pkg::HOLD_BITS-1:0] limit_i,
  output rgbd_pkg::btn_t                 state_o,
  output rgbd_pkg::btn_t                 next_o
);

  rgbd_pkg::btn_t st_q, st_d;

  always_comb begin
    st_d = st_q;
    if (down_i) begin
      if (st_q.idle) begin
        st_d.fresh = 1'b1;
        st_d.idle  = 1'b0;
      end else if (st_q.fresh) begin
        st_d.count = st_q.count + 1'b1;
        st_d.fresh = 1'b0;
      end else if (st_q.count != '0 && st_q.count < limit_i) begin
        st_d.count = st_q.count + 1'b1;
      end
      if (st_d.count >= limit_i) begin
        st_d.long_hold = 1'b1;
        st_d.count     = limit_i;
      end
    end else begin
      st_d.idle      = 1'b1;
      st_d.fresh     = 1'b0;
      st_d.count     = '0;
      st_d.long_hold = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.idle      <= 1'b1;
      st_q.fresh     <= 1'b0;
      st_q.count     <= '0;
      st_q.long_hold <= 1'b0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;
  assign next_o  = st_d;

endmodule
